[design/morse_char_keyer_unit_defines.svh]
// Assertion macros for the Morse character keyer
`ifndef MORSE_CHAR_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHAR_KEYER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mck: implication check failed");
`define MCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mck: next-cycle check failed");
`else
`define MCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/mck_pkg.sv]
// Types, constants and the letter table of the Morse character keyer
package mck_pkg;

	localparam int CHAR_W     = 8;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int LETTER_IDX_W = 5;
	localparam int MAX_ELEM   = 4;
	localparam int ELEM_CNT_W = $clog2(MAX_ELEM + 1);
	localparam int ELEM_IDX_W = $clog2(MAX_ELEM);
	localparam int SEG_W      = $clog2(2 * MAX_ELEM + 1);

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;

	localparam logic [HOLD_W-1:0] DOT_RST        = 16'd200;
	localparam logic [HOLD_W-1:0] DASH_RST       = 16'd600;
	localparam logic [HOLD_W-1:0] ELEM_GAP_RST   = 16'd200;
	localparam logic [HOLD_W-1:0] LETTER_GAP_RST = 16'd600;
	localparam logic [HOLD_W-1:0] WORD_GAP_RST   = 16'd1400;

	typedef enum logic [1:0] {
		SYM_NONE  = 2'd0,
		SYM_DOT   = 2'd1,
		SYM_DASH  = 2'd2,
		SYM_SPACE = 2'd3
	} sym_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOT        = 3'd0,
		REG_DASH       = 3'd1,
		REG_ELEM_GAP   = 3'd2,
		REG_LETTER_GAP = 3'd3,
		REG_WORD_GAP   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [HOLD_W-1:0] dot_ms;
		logic [HOLD_W-1:0] dash_ms;
		logic [HOLD_W-1:0] element_gap_ms;
		logic [HOLD_W-1:0] char_space_ms;
		logic [HOLD_W-1:0] word_space_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic              is_space;
		logic              final_char;
		logic [HOLD_W-1:0] pattern;
	} dec_item_t;

	typedef struct packed {
		logic [ELEM_CNT_W-1:0] cnt;
		logic [MAX_ELEM-1:0]   dash;
	} elem_list_t;

	typedef struct packed {
		logic       is_space;
		logic       final_char;
		elem_list_t elems;
	} elem_item_t;

	typedef struct packed {
		logic              led_level;
		logic [HOLD_W-1:0] hold_ms;
		sym_t              text_symbol;
		logic [1:0]        text_count;
		logic              run_end;
	} seg_t;

	function automatic logic [HOLD_W-1:0] letter_pattern(input logic [LETTER_IDX_W-1:0] idx);
		logic [HOLD_W-1:0] p;
		case (idx)
			5'd0:  p = 16'hB800;
			5'd1:  p = 16'hEA80;
			5'd2:  p = 16'hEBA0;
			5'd3:  p = 16'hEA00;
			5'd4:  p = 16'h8000;
			5'd5:  p = 16'hAE80;
			5'd6:  p = 16'hEE80;
			5'd7:  p = 16'hAA00;
			5'd8:  p = 16'hA000;
			5'd9:  p = 16'hBBB8;
			5'd10: p = 16'hEB80;
			5'd11: p = 16'hBA80;
			5'd12: p = 16'hEE00;
			5'd13: p = 16'hE800;
			5'd14: p = 16'hEEE0;
			5'd15: p = 16'hBBA0;
			5'd16: p = 16'hEEB8;
			5'd17: p = 16'hBA00;
			5'd18: p = 16'hA800;
			5'd19: p = 16'hE000;
			5'd20: p = 16'hAE00;
			5'd21: p = 16'hAB80;
			5'd22: p = 16'hBB80;
			5'd23: p = 16'hEAE0;
			5'd24: p = 16'hEBB8;
			5'd25: p = 16'hEEA0;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Each element starts at the top bit and is followed by one off unit.
	function automatic elem_list_t parse_pattern(input logic [HOLD_W-1:0] pat);
		elem_list_t        r;
		logic [HOLD_W-1:0] rem;
		logic              stop;
		logic              is_dash;
		r    = '0;
		rem  = pat;
		stop = 1'b0;
		for (int e = 0; e < MAX_ELEM; e++) begin
			is_dash = rem[HOLD_W-2] & rem[HOLD_W-3];
			if (!stop && rem[HOLD_W-1]) begin
				r.dash[e] = is_dash;
				r.cnt     = r.cnt + ELEM_CNT_W'(1);
				rem       = is_dash ? (rem << 4) : (rem << 2);
			end else begin
				stop = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

[design/mck_if.sv]
// Character input and segment output channel interfaces
interface mck_in_if import mck_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              final_char;

	modport source (output valid, output char_code, output final_char, input ready);
	modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface mck_out_if import mck_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              led_level;
	logic [HOLD_W-1:0] hold_ms;
	logic [1:0]        text_symbol;
	logic [1:0]        text_count;
	logic              run_end;

	modport source (output valid, output led_level, output hold_ms, output text_symbol,
		output text_count, output run_end, input ready);
	modport sink (input valid, input led_level, input hold_ms, input text_symbol,
		input text_count, input run_end, output ready);
endinterface

[design/mck_decode.sv]
// Stage 1: classify the character and look up its letter pattern
module mck_decode import mck_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mck_in_if.sink    char_in,
	output logic      valid_s1,
	output dec_item_t item_s1,
	input  logic      ready_s2
);

	logic                    is_upper;
	logic                    is_lower;
	logic                    is_space;
	logic [CHAR_W-1:0]       offset;
	logic [LETTER_IDX_W-1:0] letter_idx;

	always_comb begin
		is_upper   = (char_in.char_code >= CHAR_UP_A) && (char_in.char_code <= CHAR_UP_Z);
		is_lower   = (char_in.char_code >= CHAR_LO_A) && (char_in.char_code <= CHAR_LO_Z);
		is_space   = (char_in.char_code == CHAR_SPACE);
		offset     = is_upper ? (char_in.char_code - CHAR_UP_A) : (char_in.char_code - CHAR_LO_A);
		letter_idx = offset[LETTER_IDX_W-1:0];
	end

	assign char_in.ready = !valid_s1 || ready_s2;

	// drop characters that key nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid && (is_upper || is_lower || is_space);
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			item_s1.is_space   <= is_space;
			item_s1.final_char <= char_in.final_char;
			item_s1.pattern    <= is_space ? '0 : letter_pattern(letter_idx);
		end
	end

endmodule

[design/mck_parse.sv]
// Stage 2: split the on/off pattern into a list of dots and dashes
module mck_parse import mck_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  dec_item_t  item_s1,
	output logic       ready_s2,
	output logic       valid_s2,
	output elem_item_t item_s2,
	input  logic       ready_s3
);

	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			item_s2.is_space   <= item_s1.is_space;
			item_s2.final_char <= item_s1.final_char;
			item_s2.elems      <= parse_pattern(item_s1.pattern);
		end
	end

endmodule

[design/mck_sequencer.sv]
// Stages 3 and 4: step through the segments of a character into the output register
module mck_sequencer import mck_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_regs_t  cfg,
	input  logic       valid_s2,
	input  elem_item_t item_s2,
	output logic       ready_s3,
	mck_out_if.source  seg_out
);

	logic                  valid_s3;
	elem_item_t            item_s3;
	logic [HOLD_W-1:0]     end_hold_s3;
	logic [SEG_W-1:0]      seg_q;
	logic                  valid_s4;
	seg_t                  seg_s4;
	seg_t                  seg_next;
	logic                  last_seg;
	logic                  load_s4;
	logic [HOLD_W-1:0]     total;
	logic [HOLD_W-1:0]     end_hold;
	logic [ELEM_IDX_W-1:0] elem_idx;

	always_comb begin
		total    = item_s2.final_char ? cfg.word_space_ms : cfg.char_space_ms;
		end_hold = (total > cfg.element_gap_ms) ? (total - cfg.element_gap_ms) : '0;
	end

	always_comb begin
		elem_idx = seg_q[ELEM_IDX_W:1];
		last_seg = item_s3.is_space || (seg_q == {item_s3.elems.cnt, 1'b0});
		load_s4  = valid_s3 && (!valid_s4 || seg_out.ready);
		ready_s3 = !valid_s3 || (load_s4 && last_seg);
		if (item_s3.is_space) begin
			seg_next = '{1'b0, cfg.word_space_ms, SYM_SPACE, 2'd3, 1'b1};
		end else if (last_seg) begin
			seg_next = '{1'b0, end_hold_s3, SYM_SPACE, 2'd1, 1'b1};
		end else if (!seg_q[0]) begin
			if (item_s3.elems.dash[elem_idx]) begin
				seg_next = '{1'b1, cfg.dash_ms, SYM_DASH, 2'd1, 1'b0};
			end else begin
				seg_next = '{1'b1, cfg.dot_ms, SYM_DOT, 2'd1, 1'b0};
			end
		end else begin
			seg_next = '{1'b0, cfg.element_gap_ms, SYM_NONE, 2'd0, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			seg_q    <= '0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= valid_s2;
				seg_q    <= '0;
			end else if (load_s4) begin
				seg_q <= seg_q + SEG_W'(1);
			end
			if (load_s4) begin
				valid_s4 <= 1'b1;
			end else if (seg_out.ready) begin
				valid_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			item_s3     <= item_s2;
			end_hold_s3 <= end_hold;
		end
		if (load_s4) begin
			seg_s4 <= seg_next;
		end
	end

	assign seg_out.valid       = valid_s4;
	assign seg_out.led_level   = seg_s4.led_level;
	assign seg_out.hold_ms     = seg_s4.hold_ms;
	assign seg_out.text_symbol = seg_s4.text_symbol;
	assign seg_out.text_count  = seg_s4.text_count;
	assign seg_out.run_end     = seg_s4.run_end;

endmodule

[design/morse_char_keyer_unit.sv]
// Morse character keyer top level: timing registers, pipeline and checks
//
// char_in takes one ASCII character and a last-of-message flag per item.
// Letters of either case and the space key; every other character is
// dropped in the first stage and yields nothing. seg_out gives one keying
// segment per item: LED level, hold time in ms, text symbol, repeat count,
// and run_end on the last segment of a character.
// The timing registers are written through cfg_we/cfg_index/cfg_data and
// are read while segments are built; indexes past the word gap are ignored.
// The first segment of a character passes the decode, parse and sequencer
// stages and the output register before it is on seg_out.
// Throughput: while seg_out is ready the sequencer issues one segment per
// cycle; a letter of n elements gives 2n+1 segments (3 to 9) and a space
// one. The decode and parse stages hold up to two more characters while it
// works, so segments of back-to-back characters follow with no gap.
// Reset empties the pipeline and loads the default timings (200, 600,
// 200, 600, 1400 ms). When seg_out stalls the output register holds its
// segment, the stages behind it fill, and char_in.ready falls.
`include "morse_char_keyer_unit_defines.svh"
module morse_char_keyer_unit import mck_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mck_in_if.sink               char_in,
	mck_out_if.source            seg_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HOLD_W-1:0]    cfg_data
);

	cfg_regs_t  cfg_q;
	logic       valid_s1;
	dec_item_t  item_s1;
	logic       ready_s2;
	logic       valid_s2;
	elem_item_t item_s2;
	logic       ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{DOT_RST, DASH_RST, ELEM_GAP_RST, LETTER_GAP_RST, WORD_GAP_RST};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DOT:        cfg_q.dot_ms         <= cfg_data;
				REG_DASH:       cfg_q.dash_ms        <= cfg_data;
				REG_ELEM_GAP:   cfg_q.element_gap_ms <= cfg_data;
				REG_LETTER_GAP: cfg_q.char_space_ms  <= cfg_data;
				REG_WORD_GAP:   cfg_q.word_space_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	mck_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.ready_s2 (ready_s2)
	);

	mck_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.ready_s2 (ready_s2),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.ready_s3 (ready_s3)
	);

	mck_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.ready_s3 (ready_s3),
		.seg_out  (seg_out)
	);

	`MCK_ASSERT_IMP(a_on_not_last, clk, arst_n, seg_out.valid && seg_out.led_level,
		!seg_out.run_end && (seg_out.text_symbol == SYM_DOT || seg_out.text_symbol == SYM_DASH))
	`MCK_ASSERT_IMP(a_space_off_end, clk, arst_n, seg_out.valid && seg_out.text_symbol == SYM_SPACE,
		!seg_out.led_level && seg_out.run_end)
	`MCK_ASSERT_IMP(a_gap_no_text, clk, arst_n, seg_out.valid && !seg_out.led_level && !seg_out.run_end,
		seg_out.text_symbol == SYM_NONE && seg_out.text_count == 2'd0)
	`MCK_ASSERT_NXT(a_space_fast, clk, arst_n, valid_s1 && ready_s2 && item_s1.is_space,
		valid_s2 && item_s2.elems.cnt == '0)

endmodule
